// ----- sv/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Shared widths, constants and types for the rotation datapath.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int FRAC_BITS = 28;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int MAT_W     = PROD_W + 2;
   localparam int MUL_W     = MAT_W + SAMPLE_W;
   localparam int ACC_W     = MUL_W + 3;
   localparam int RND_W     = ACC_W - FRAC_BITS;
   localparam int NUM_AXES  = 3;
   localparam int NUM_ENTRY = NUM_AXES * NUM_AXES;

   localparam logic signed [MAT_W-1:0] MAT_ONE   = MAT_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [RND_W-1:0] RND_MAX   = RND_W'(32767);
   localparam logic signed [RND_W-1:0] RND_MIN   = -RND_W'(32768);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_entry_type;
   typedef logic signed [MAT_W-1:0]    mat_entry_type;

   typedef struct packed {
      sample_type x;
      sample_type y;
      sample_type z;
   } vec_type;

   typedef struct packed {
      prod_entry_type xx;
      prod_entry_type yy;
      prod_entry_type zz;
      prod_entry_type xy;
      prod_entry_type xz;
      prod_entry_type yz;
      prod_entry_type wx;
      prod_entry_type wy;
      prod_entry_type wz;
   } prod_type;

   typedef mat_entry_type mat_type [NUM_ENTRY];

endpackage

// ----- sv/qvr_matrix.sv -----
// ----------------------------------------------------------------------------
// Direction-cosine matrix builder
// Two register stages: quaternion products, then the nine matrix entries.
// ----------------------------------------------------------------------------
module qvr_matrix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  qvr_pkg::sample_type     quat_w,
   input  qvr_pkg::sample_type     quat_x,
   input  qvr_pkg::sample_type     quat_y,
   input  qvr_pkg::sample_type     quat_z,
   input  qvr_pkg::vec_type        body_in,
   output logic                    out_valid,
   output qvr_pkg::mat_type        mat_out,
   output qvr_pkg::vec_type        body_out
);

   logic               prod_valid_ff;
   qvr_pkg::prod_type  prod_ff;
   qvr_pkg::prod_type  prod_in;
   qvr_pkg::vec_type   prod_body_ff;

   logic               mat_valid_ff;
   qvr_pkg::mat_type   mat_ff;
   qvr_pkg::mat_type   mat_in;
   qvr_pkg::vec_type   mat_body_ff;

   qvr_pkg::mat_entry_type xx2, yy2, zz2, xy2, xz2, yz2, wx2, wy2, wz2;

   always_comb begin
      prod_in.xx = quat_x * quat_x;
      prod_in.yy = quat_y * quat_y;
      prod_in.zz = quat_z * quat_z;
      prod_in.xy = quat_x * quat_y;
      prod_in.xz = quat_x * quat_z;
      prod_in.yz = quat_y * quat_z;
      prod_in.wx = quat_w * quat_x;
      prod_in.wy = quat_w * quat_y;
      prod_in.wz = quat_w * quat_z;
   end

   always_comb begin
      xx2 = {prod_ff.xx[qvr_pkg::PROD_W-1], prod_ff.xx, 1'b0};
      yy2 = {prod_ff.yy[qvr_pkg::PROD_W-1], prod_ff.yy, 1'b0};
      zz2 = {prod_ff.zz[qvr_pkg::PROD_W-1], prod_ff.zz, 1'b0};
      xy2 = {prod_ff.xy[qvr_pkg::PROD_W-1], prod_ff.xy, 1'b0};
      xz2 = {prod_ff.xz[qvr_pkg::PROD_W-1], prod_ff.xz, 1'b0};
      yz2 = {prod_ff.yz[qvr_pkg::PROD_W-1], prod_ff.yz, 1'b0};
      wx2 = {prod_ff.wx[qvr_pkg::PROD_W-1], prod_ff.wx, 1'b0};
      wy2 = {prod_ff.wy[qvr_pkg::PROD_W-1], prod_ff.wy, 1'b0};
      wz2 = {prod_ff.wz[qvr_pkg::PROD_W-1], prod_ff.wz, 1'b0};

      mat_in[0] = qvr_pkg::MAT_ONE - yy2 - zz2;
      mat_in[1] = xy2 - wz2;
      mat_in[2] = xz2 + wy2;
      mat_in[3] = xy2 + wz2;
      mat_in[4] = qvr_pkg::MAT_ONE - xx2 - zz2;
      mat_in[5] = yz2 - wx2;
      mat_in[6] = xz2 - wy2;
      mat_in[7] = yz2 + wx2;
      mat_in[8] = qvr_pkg::MAT_ONE - xx2 - yy2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         mat_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         mat_valid_ff  <= prod_valid_ff;
      end
      prod_ff      <= prod_in;
      prod_body_ff <= body_in;
      mat_ff       <= mat_in;
      mat_body_ff  <= prod_body_ff;
   end

   assign out_valid = mat_valid_ff;
   assign mat_out   = mat_ff;
   assign body_out  = mat_body_ff;

endmodule

// ----- sv/qvr_mat_vec.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector product with rounding and saturation
// Three register stages: nine products, rounded row sums, clipped result.
// ----------------------------------------------------------------------------
module qvr_mat_vec (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  qvr_pkg::mat_type        mat_in,
   input  qvr_pkg::vec_type        body_in,
   output logic                    out_valid,
   output qvr_pkg::vec_type        nav_out,
   output logic                    sat_out
);

   typedef logic signed [qvr_pkg::MUL_W-1:0] mul_entry_type;
   typedef logic signed [qvr_pkg::ACC_W-1:0] acc_entry_type;
   typedef logic signed [qvr_pkg::RND_W-1:0] rnd_entry_type;

   qvr_pkg::sample_type body_arr [qvr_pkg::NUM_AXES];

   logic          mul_valid_ff;
   mul_entry_type mul_ff [qvr_pkg::NUM_ENTRY];
   mul_entry_type mul_in [qvr_pkg::NUM_ENTRY];

   logic          acc_valid_ff;
   acc_entry_type acc_ff [qvr_pkg::NUM_AXES];
   acc_entry_type acc_in [qvr_pkg::NUM_AXES];

   rnd_entry_type       rnd    [qvr_pkg::NUM_AXES];
   qvr_pkg::sample_type clip   [qvr_pkg::NUM_AXES];
   logic                clip_hit [qvr_pkg::NUM_AXES];

   logic             out_valid_ff;
   qvr_pkg::vec_type nav_ff;
   qvr_pkg::vec_type nav_in;
   logic             sat_ff;
   logic             sat_in;

   always_comb begin
      body_arr[0] = body_in.x;
      body_arr[1] = body_in.y;
      body_arr[2] = body_in.z;
      for (int k = 0; k < qvr_pkg::NUM_ENTRY; k++) begin
         mul_in[k] = qvr_pkg::MUL_W'(mat_in[k])
                   * qvr_pkg::MUL_W'(body_arr[k % qvr_pkg::NUM_AXES]);
      end
   end

   always_comb begin
      for (int i = 0; i < qvr_pkg::NUM_AXES; i++) begin
         acc_in[i] = qvr_pkg::ACC_W'(mul_ff[i * qvr_pkg::NUM_AXES])
                   + qvr_pkg::ACC_W'(mul_ff[i * qvr_pkg::NUM_AXES + 1])
                   + qvr_pkg::ACC_W'(mul_ff[i * qvr_pkg::NUM_AXES + 2])
                   + qvr_pkg::ACC_HALF;
      end
   end

   always_comb begin
      for (int i = 0; i < qvr_pkg::NUM_AXES; i++) begin
         rnd[i] = acc_ff[i][qvr_pkg::ACC_W-1:qvr_pkg::FRAC_BITS];
         if (rnd[i] > qvr_pkg::RND_MAX) begin
            clip[i]     = qvr_pkg::SAMPLE_MAX;
            clip_hit[i] = 1'b1;
         end else if (rnd[i] < qvr_pkg::RND_MIN) begin
            clip[i]     = qvr_pkg::SAMPLE_MIN;
            clip_hit[i] = 1'b1;
         end else begin
            clip[i]     = rnd[i][qvr_pkg::SAMPLE_W-1:0];
            clip_hit[i] = 1'b0;
         end
      end
      nav_in.x = clip[0];
      nav_in.y = clip[1];
      nav_in.z = clip[2];
      sat_in   = clip_hit[0] | clip_hit[1] | clip_hit[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         acc_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         acc_valid_ff <= mul_valid_ff;
         out_valid_ff <= acc_valid_ff;
      end
      mul_ff <= mul_in;
      acc_ff <= acc_in;
      nav_ff <= nav_in;
      sat_ff <= sat_in;
   end

   assign out_valid = out_valid_ff;
   assign nav_out   = nav_ff;
   assign sat_out   = sat_ff;

endmodule

// ----- sv/quaternion_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a body-frame vector into the navigation frame by a Q1.14 quaternion.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge where start is high and busy is
// low. It carries the quaternion on req_quat_w/x/y/z and the body-frame vector
// on req_body_x/y/z.
// Once through the pipeline, the result appears on rsp_nav_x/y/z and rsp_saturated for
// exactly one cycle, marked by rsp_strobe, and is taken at the edge that ends
// that cycle. The receiver cannot hold results off and the block never needs
// it to.
// The datapath is a five-stage pipeline: quaternion products, matrix entries,
// matrix-by-vector products, rounded row sums, and saturation. A new
// transaction may be accepted in every cycle, so throughput is one per cycle;
// results leave in the order of acceptance. Busy is high only while reset is
// asserted. Reset clears every valid bit, so transactions in flight at reset
// are dropped and no result follows.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qvr_pkg::sample_type req_quat_w,
   input  qvr_pkg::sample_type req_quat_x,
   input  qvr_pkg::sample_type req_quat_y,
   input  qvr_pkg::sample_type req_quat_z,
   input  qvr_pkg::sample_type req_body_x,
   input  qvr_pkg::sample_type req_body_y,
   input  qvr_pkg::sample_type req_body_z,
   output logic                rsp_strobe,
   output qvr_pkg::sample_type rsp_nav_x,
   output qvr_pkg::sample_type rsp_nav_y,
   output qvr_pkg::sample_type rsp_nav_z,
   output logic                rsp_saturated
);

   logic             accept;
   qvr_pkg::vec_type body_vec;
   logic             mat_valid;
   qvr_pkg::mat_type mat;
   qvr_pkg::vec_type mat_body;
   qvr_pkg::vec_type nav_vec;

   assign busy     = reset;
   assign accept   = start & ~busy;
   assign body_vec = '{x: req_body_x, y: req_body_y, z: req_body_z};

   qvr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .body_in   (body_vec),
      .out_valid (mat_valid),
      .mat_out   (mat),
      .body_out  (mat_body)
   );

   qvr_mat_vec u_mat_vec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .mat_in    (mat),
      .body_in   (mat_body),
      .out_valid (rsp_strobe),
      .nav_out   (nav_vec),
      .sat_out   (rsp_saturated)
   );

   assign rsp_nav_x = nav_vec.x;
   assign rsp_nav_y = nav_vec.y;
   assign rsp_nav_z = nav_vec.z;

endmodule

// ----- sv/qvr_checker.sv -----
// ----------------------------------------------------------------------------
// Quaternion vector rotation port checker
// Checks transaction timing and the saturation flag at the top-level ports.
// ----------------------------------------------------------------------------
module qvr_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input qvr_pkg::sample_type rsp_nav_x,
   input qvr_pkg::sample_type rsp_nav_y,
   input qvr_pkg::sample_type rsp_nav_z,
   input logic                rsp_strobe,
   input logic                rsp_saturated
);

   logic accept;
   logic all_inside;

   assign accept = start & ~busy;
   assign all_inside =
      (rsp_nav_x != qvr_pkg::SAMPLE_MAX) && (rsp_nav_x != qvr_pkg::SAMPLE_MIN) &&
      (rsp_nav_y != qvr_pkg::SAMPLE_MAX) && (rsp_nav_y != qvr_pkg::SAMPLE_MIN) &&
      (rsp_nav_z != qvr_pkg::SAMPLE_MAX) && (rsp_nav_z != qvr_pkg::SAMPLE_MIN);

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_strobe)
      else $error("Accepted transaction gave no result five cycles later.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 5))
      else $error("Result without a matching accepted transaction.");

   a_flag_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && all_inside) |-> !rsp_saturated)
      else $error("Saturation flagged although no component is at a limit.");

   a_ready_out_of_reset: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("Busy raised outside reset.");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_nav_x     (rsp_nav_x),
   .rsp_nav_y     (rsp_nav_y),
   .rsp_nav_z     (rsp_nav_z),
   .rsp_strobe    (rsp_strobe),
   .rsp_saturated (rsp_saturated)
);

// ----- sim/qvr_rotation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation checker
// Watches the request and response channels of the rotation block, works out
// the rotated vector of every accepted transaction and compares each response
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module qvr_rotation_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  qvr_pkg::sample_type req_quat_w,
   input  qvr_pkg::sample_type req_quat_x,
   input  qvr_pkg::sample_type req_quat_y,
   input  qvr_pkg::sample_type req_quat_z,
   input  qvr_pkg::sample_type req_body_x,
   input  qvr_pkg::sample_type req_body_y,
   input  qvr_pkg::sample_type req_body_z,
   input  logic                rsp_strobe,
   input  qvr_pkg::sample_type rsp_nav_x,
   input  qvr_pkg::sample_type rsp_nav_y,
   input  qvr_pkg::sample_type rsp_nav_z,
   input  logic                rsp_saturated,
   output int                  fail_count,
   output int                  nav_pending,
   output int                  nav_checked,
   output int                  nav_clipped
);

   typedef struct {
      qvr_pkg::sample_type nav_x;
      qvr_pkg::sample_type nav_y;
      qvr_pkg::sample_type nav_z;
      logic                saturated;
   } nav_result_type;

   nav_result_type expected_nav_q[$];

   int fail_total    = 0;
   int pending_total = 0;
   int checked_total = 0;
   int clipped_total = 0;

   assign fail_count  = fail_total;
   assign nav_pending = pending_total;
   assign nav_checked = checked_total;
   assign nav_clipped = clipped_total;

   function automatic nav_result_type rotate_vector(
      input qvr_pkg::sample_type w, input qvr_pkg::sample_type x,
      input qvr_pkg::sample_type y, input qvr_pkg::sample_type z,
      input qvr_pkg::sample_type bx, input qvr_pkg::sample_type by,
      input qvr_pkg::sample_type bz
   );
      longint              qw, qx, qy, qz;
      longint              unit_q28;
      longint              dcm[qvr_pkg::NUM_ENTRY];
      longint              body[qvr_pkg::NUM_AXES];
      longint              acc;
      longint              rounded;
      qvr_pkg::sample_type comp[qvr_pkg::NUM_AXES];
      logic                clipped;
      nav_result_type      res;
      qw = longint'(w);
      qx = longint'(x);
      qy = longint'(y);
      qz = longint'(z);
      body[0] = longint'(bx);
      body[1] = longint'(by);
      body[2] = longint'(bz);
      unit_q28 = longint'(1) <<< qvr_pkg::FRAC_BITS;
      clipped = 1'b0;
      dcm[0] = unit_q28 - 2 * (qy * qy) - 2 * (qz * qz);
      dcm[1] = 2 * (qx * qy - qw * qz);
      dcm[2] = 2 * (qx * qz + qw * qy);
      dcm[3] = 2 * (qx * qy + qw * qz);
      dcm[4] = unit_q28 - 2 * (qx * qx) - 2 * (qz * qz);
      dcm[5] = 2 * (qy * qz - qw * qx);
      dcm[6] = 2 * (qx * qz - qw * qy);
      dcm[7] = 2 * (qy * qz + qw * qx);
      dcm[8] = unit_q28 - 2 * (qx * qx) - 2 * (qy * qy);
      for (int row = 0; row < qvr_pkg::NUM_AXES; row++) begin
         acc = dcm[row * 3] * body[0] + dcm[row * 3 + 1] * body[1]
             + dcm[row * 3 + 2] * body[2];
         // Round to nearest with halves going towards plus infinity.
         rounded = (acc + (longint'(1) <<< (qvr_pkg::FRAC_BITS - 1)))
                   >>> qvr_pkg::FRAC_BITS;
         if (rounded > longint'(qvr_pkg::SAMPLE_MAX)) begin
            rounded = longint'(qvr_pkg::SAMPLE_MAX);
            clipped = 1'b1;
         end else if (rounded < longint'(qvr_pkg::SAMPLE_MIN)) begin
            rounded = longint'(qvr_pkg::SAMPLE_MIN);
            clipped = 1'b1;
         end
         comp[row] = qvr_pkg::sample_type'(rounded);
      end
      res.nav_x = comp[0];
      res.nav_y = comp[1];
      res.nav_z = comp[2];
      res.saturated = clipped;
      return res;
   endfunction

   function automatic int compare_field(input string name,
                                        input qvr_pkg::sample_type exp_val,
                                        input qvr_pkg::sample_type act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      nav_result_type exp_nav;
      int             errs;
      if (rsp_strobe) begin
         if (expected_nav_q.size() == 0) begin
            $error("Response with no outstanding transaction: nav %0d %0d %0d",
                   rsp_nav_x, rsp_nav_y, rsp_nav_z);
            fail_total <= fail_total + 1;
         end else begin
            exp_nav = expected_nav_q.pop_front();
            errs = compare_field("nav_x", exp_nav.nav_x, rsp_nav_x)
                 + compare_field("nav_y", exp_nav.nav_y, rsp_nav_y)
                 + compare_field("nav_z", exp_nav.nav_z, rsp_nav_z)
                 + compare_field("saturated",
                                 qvr_pkg::sample_type'(exp_nav.saturated),
                                 qvr_pkg::sample_type'(rsp_saturated));
            if (errs != 0) begin
               fail_total <= fail_total + 1;
            end
            checked_total <= checked_total + 1;
            if (exp_nav.saturated) begin
               clipped_total <= clipped_total + 1;
            end
         end
      end
      if (!reset && start && !busy) begin
         expected_nav_q.push_back(rotate_vector(req_quat_w, req_quat_x, req_quat_y,
            req_quat_z, req_body_x, req_body_y, req_body_z));
      end
      pending_total <= expected_nav_q.size();
   end

endmodule

// ----- sim/tb_quaternion_vector_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation testbench
// Drives directed and random rotation transactions into the block with random
// gaps, and lets a separate checker predict and compare every response.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   qvr_pkg::sample_type req_quat_w;
   qvr_pkg::sample_type req_quat_x;
   qvr_pkg::sample_type req_quat_y;
   qvr_pkg::sample_type req_quat_z;
   qvr_pkg::sample_type req_body_x;
   qvr_pkg::sample_type req_body_y;
   qvr_pkg::sample_type req_body_z;
   logic                rsp_strobe;
   qvr_pkg::sample_type rsp_nav_x;
   qvr_pkg::sample_type rsp_nav_y;
   qvr_pkg::sample_type rsp_nav_z;
   logic                rsp_saturated;

   int  fail_count;
   int  nav_pending;
   int  nav_checked;
   int  nav_clipped;
   int  leftover_fails;
   bit  no_gaps;

   quaternion_vector_rotate DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_quat_w    (req_quat_w),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_body_x    (req_body_x),
      .req_body_y    (req_body_y),
      .req_body_z    (req_body_z),
      .rsp_strobe    (rsp_strobe),
      .rsp_nav_x     (rsp_nav_x),
      .rsp_nav_y     (rsp_nav_y),
      .rsp_nav_z     (rsp_nav_z),
      .rsp_saturated (rsp_saturated)
   );

   qvr_rotation_checker rotation_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_quat_w    (req_quat_w),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_body_x    (req_body_x),
      .req_body_y    (req_body_y),
      .req_body_z    (req_body_z),
      .rsp_strobe    (rsp_strobe),
      .rsp_nav_x     (rsp_nav_x),
      .rsp_nav_y     (rsp_nav_y),
      .rsp_nav_z     (rsp_nav_z),
      .rsp_saturated (rsp_saturated),
      .fail_count    (fail_count),
      .nav_pending   (nav_pending),
      .nav_checked   (nav_checked),
      .nav_clipped   (nav_clipped)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("Timed out with %0d responses outstanding.", nav_pending);
      $display("FAIL");
      $finish;
   end

   function automatic qvr_pkg::sample_type raw_sample();
      return qvr_pkg::sample_type'($urandom_range(0, 65535));
   endfunction

   function automatic qvr_pkg::sample_type corner_sample();
      case ($urandom_range(0, 6))
         0: return qvr_pkg::sample_type'(0);
         1: return qvr_pkg::sample_type'(1);
         2: return qvr_pkg::sample_type'(-1);
         3: return qvr_pkg::SAMPLE_MAX;
         4: return qvr_pkg::SAMPLE_MIN;
         5: return qvr_pkg::sample_type'(16384);
         default: return qvr_pkg::sample_type'(-16384);
      endcase
   endfunction

   task automatic unit_quaternion(output qvr_pkg::sample_type w,
                                  output qvr_pkg::sample_type x,
                                  output qvr_pkg::sample_type y,
                                  output qvr_pkg::sample_type z);
      real a, b, c, d, norm, scale;
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      norm = $sqrt(a * a + b * b + c * c + d * d);
      if (norm < 1.0) begin
         a = 1.0;
         norm = 1.0;
      end
      // Mostly unit length, sometimes a little off so that saturation can occur.
      scale = 16384.0 * (($urandom_range(0, 3) == 0) ?
                         (0.9 + real'($urandom_range(0, 200)) / 1000.0) : 1.0);
      w = qvr_pkg::sample_type'($rtoi(a / norm * scale));
      x = qvr_pkg::sample_type'($rtoi(b / norm * scale));
      y = qvr_pkg::sample_type'($rtoi(c / norm * scale));
      z = qvr_pkg::sample_type'($rtoi(d / norm * scale));
   endtask

   task automatic send_rotation(input qvr_pkg::sample_type w,
                                input qvr_pkg::sample_type x,
                                input qvr_pkg::sample_type y,
                                input qvr_pkg::sample_type z,
                                input qvr_pkg::sample_type bx,
                                input qvr_pkg::sample_type by,
                                input qvr_pkg::sample_type bz);
      while (!no_gaps && $urandom_range(0, 99) < 13) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_quat_w <= w;
      req_quat_x <= x;
      req_quat_y <= y;
      req_quat_z <= z;
      req_body_x <= bx;
      req_body_y <= by;
      req_body_z <= bz;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      qvr_pkg::sample_type qw, qx, qy, qz, bx, by, bz;
      int                  mix;
      int                  drain;
      leftover_fails = 0;
      no_gaps = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_quat_w <= '0;
      req_quat_x <= '0;
      req_quat_y <= '0;
      req_quat_z <= '0;
      req_body_x <= '0;
      req_body_y <= '0;
      req_body_z <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_rotation(16384, 0, 0, 0, 1, 2, 3);
      send_rotation(16384, 0, 0, 0, qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MAX,
                    qvr_pkg::SAMPLE_MAX);
      send_rotation(16384, 0, 0, 0, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN,
                    qvr_pkg::SAMPLE_MIN);
      send_rotation(0, 0, 0, 0, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MAX, 0);
      send_rotation(-16384, 0, 0, 0, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MAX, -1);
      send_rotation(11585, 11585, 0, 0, 100, 200, 300);
      send_rotation(11585, 0, 11585, 0, 100, 200, 300);
      send_rotation(11585, 0, 0, 11585, 100, 200, 300);
      send_rotation(0, 0, 0, 16384, qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MIN, 1234);
      // Half-way cases: an entry of exactly one half times an odd sample.
      send_rotation(0, 8192, 0, 0, 0, 1, 3);
      send_rotation(0, 8192, 0, 0, 0, -1, -3);
      send_rotation(0, 0, 8192, 0, -1, 0, 5);
      send_rotation(0, 0, 8192, 0, 1, 0, -5);
      send_rotation(qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MAX,
                    qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MAX,
                    qvr_pkg::SAMPLE_MAX);
      send_rotation(qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN,
                    qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN,
                    qvr_pkg::SAMPLE_MIN);
      send_rotation(qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MAX,
                    qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MAX,
                    qvr_pkg::SAMPLE_MIN);
      send_rotation(0, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN,
                    qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MAX);
      send_rotation(0, 0, 0, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MAX,
                    qvr_pkg::SAMPLE_MAX, qvr_pkg::SAMPLE_MAX);
      send_rotation(1, -1, 1, -1, qvr_pkg::SAMPLE_MIN, qvr_pkg::SAMPLE_MIN,
                    qvr_pkg::SAMPLE_MIN);
      send_rotation(-1, 1, -1, 1, -1, -1, -1);

      for (int i = 0; i < 750; i++) begin
         no_gaps = (i >= 250 && i < 420);
         if (i == 550) begin
            start <= 1'b0;
            do @(posedge clock); while (nav_pending != 0);
         end
         mix = $urandom_range(0, 99);
         if (mix < 60) begin
            unit_quaternion(qw, qx, qy, qz);
         end else if (mix < 82) begin
            qw = raw_sample();
            qx = raw_sample();
            qy = raw_sample();
            qz = raw_sample();
         end else begin
            qw = corner_sample();
            qx = corner_sample();
            qy = corner_sample();
            qz = corner_sample();
         end
         bx = ($urandom_range(0, 4) == 0) ? corner_sample() : raw_sample();
         by = ($urandom_range(0, 4) == 0) ? corner_sample() : raw_sample();
         bz = ($urandom_range(0, 4) == 0) ? corner_sample() : raw_sample();
         send_rotation(qw, qx, qy, qz, bx, by, bz);
      end
      start <= 1'b0;

      drain = 0;
      while (nav_pending != 0 && drain < 100) begin
         @(posedge clock);
         drain++;
      end
      if (nav_pending != 0) begin
         $error("%0d expected responses never arrived", nav_pending);
         leftover_fails = nav_pending;
      end
      repeat (10) @(posedge clock);

      $display("Checked %0d rotation responses, %0d of them clipped to range,",
               nav_checked, nav_clipped);
      $display("covering unit, non-unit and extreme quaternions and half-way rounding.");
      if (fail_count == 0 && leftover_fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
